### rtl/iva_pkg.sv
// Shared types and constants for the integer vector angle block.
// Holds the CORDIC arctangent table and the stage records of the cell chains.
// No dependencies.
package iva_pkg;

   localparam int COMPONENT_BITS_DEF  = 15;
   localparam int ANGLE_FRAC_BITS_DEF = 13;
   localparam int MAX_DIMENSION_DEF   = 4;

   localparam int DIM_W        = 3;
   localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 32;
   localparam int TAB_FRAC     = 40;
   localparam int NORM_W       = 64;
   localparam int XY_W         = 40;
   localparam int ACC_W        = 46;
   localparam int SHIFT_W      = 5;

   localparam logic signed [ACC_W-1:0] HALF_PI = 46'sd1727108826179;

   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic [NORM_W-1:0]        n;
      logic [NORM_W-1:0]        r;
      logic signed [XY_W-1:0]   x;
   } sqrt_stage_type;

   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [ACC_W-1:0]  acc;
   } cordic_stage_type;

   // atan(2^-idx) with TAB_FRAC fractional bits
   function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
      logic signed [ACC_W-1:0] v;
      unique case (idx)
         0:  v = 46'sd863554413089;
         1:  v = 46'sd509785937287;
         2:  v = 46'sd269356888665;
         3:  v = 46'sd136729762476;
         4:  v = 46'sd68630207382;
         5:  v = 46'sd34348560106;
         6:  v = 46'sd17178471287;
         7:  v = 46'sd8589759836;
         8:  v = 46'sd4294945451;
         9:  v = 46'sd2147480917;
         10: v = 46'sd1073741483;
         11: v = 46'sd536870869;
         12: v = 46'sd268435451;
         13: v = 46'sd134217727;
         default: v = ACC_W'(1) << (TAB_FRAC - idx);
      endcase
      return v;
   endfunction

endpackage

### rtl/iva_front.sv
// Front end: masking, products, norms, dot product and normalization.
// Feeds the head of the square root chain. Depends on iva_pkg.
module iva_front import iva_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int MAX_DIMENSION  = MAX_DIMENSION_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             accept,
   input  logic [DIM_W-1:0]                 dimension,
   input  logic signed [COMPONENT_BITS-1:0] a_comp [4],
   input  logic signed [COMPONENT_BITS-1:0] b_comp [4],
   output sqrt_stage_type                   head
);

   localparam int PROD_W = 2 * COMPONENT_BITS;
   localparam int SUM_W  = 2 * COMPONENT_BITS + 2;

   logic                             v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [COMPONENT_BITS-1:0] a1_ff [4];
   logic signed [COMPONENT_BITS-1:0] b1_ff [4];
   logic signed [PROD_W-1:0]         aa2_ff [4];
   logic signed [PROD_W-1:0]         bb2_ff [4];
   logic signed [PROD_W-1:0]         ab2_ff [4];
   logic [SUM_W-1:0]                 na3_ff, nb3_ff;
   logic signed [SUM_W-1:0]          dot3_ff;
   logic [2*SUM_W-1:0]               p4_ff;
   logic signed [2*SUM_W-1:0]        d4_ff;
   logic signed [SUM_W-1:0]          dot4_ff, dot5_ff;
   logic                             zero4_ff, zero5_ff;
   logic [NORM_W-1:0]                s5_ff;
   logic [SHIFT_W-1:0]               k5_ff;
   logic [NORM_W-1:0]                p_wide, s_in;
   logic [SHIFT_W-1:0]               k_in;
   logic [SUM_W-1:0]                 na_in, nb_in;
   logic signed [SUM_W-1:0]          dot_in;
   logic                             use_comp [4];
   sqrt_stage_type                   head_ff, head_in;

   always_comb begin
      use_comp[0] = 1'b1;
      use_comp[1] = 1'b1;
      use_comp[2] = (MAX_DIMENSION >= 3) && (dimension >= DIM_W'(3));
      use_comp[3] = (MAX_DIMENSION >= 4) && (dimension >= DIM_W'(4));
   end

   always_comb begin
      na_in  = '0;
      nb_in  = '0;
      dot_in = '0;
      for (int i = 0; i < 4; i++) begin
         na_in  = na_in + SUM_W'(unsigned'(aa2_ff[i]));
         nb_in  = nb_in + SUM_W'(unsigned'(bb2_ff[i]));
         dot_in = dot_in + SUM_W'(ab2_ff[i]);
      end
   end

   // k: shift pairs that bring the norm product up to [2^60, 2^62)
   always_comb begin
      p_wide = NORM_W'(p4_ff);
      k_in   = '0;
      for (int j = 0; j < 31; j++) begin
         if (p_wide[2*j +: 2] != 2'b00) begin
            k_in = SHIFT_W'(30 - j);
         end
      end
      s_in = p_wide - NORM_W'(unsigned'(d4_ff));
   end

   always_comb begin
      head_in.valid = v5_ff;
      head_in.zero  = zero5_ff;
      head_in.n     = s5_ff << {k5_ff, 1'b0};
      head_in.r     = '0;
      head_in.x     = XY_W'(NORM_W'(dot5_ff) << k5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
         head_ff <= '0;
      end else if (adv) begin
         v1_ff   <= accept;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         v5_ff   <= v4_ff;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            a1_ff[i]  <= use_comp[i] ? a_comp[i] : '0;
            b1_ff[i]  <= use_comp[i] ? b_comp[i] : '0;
            aa2_ff[i] <= a1_ff[i] * a1_ff[i];
            bb2_ff[i] <= b1_ff[i] * b1_ff[i];
            ab2_ff[i] <= a1_ff[i] * b1_ff[i];
         end
         na3_ff   <= na_in;
         nb3_ff   <= nb_in;
         dot3_ff  <= dot_in;
         p4_ff    <= na3_ff * nb3_ff;
         d4_ff    <= dot3_ff * dot3_ff;
         dot4_ff  <= dot3_ff;
         zero4_ff <= (na3_ff == '0) || (nb3_ff == '0);
         s5_ff    <= s_in;
         k5_ff    <= k_in;
         dot5_ff  <= dot4_ff;
         zero5_ff <= zero4_ff;
      end
   end

   assign head = head_ff;

endmodule

### rtl/iva_sqrt_cell.sv
// One digit cell of the pipelined integer square root chain.
// Depends on iva_pkg.
module iva_sqrt_cell import iva_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  sqrt_stage_type prev,
   output sqrt_stage_type next
);

   localparam logic [NORM_W-1:0] BIT = NORM_W'(1) << (62 - 2 * STEP);

   sqrt_stage_type    next_ff, next_in;
   logic [NORM_W-1:0] trial;

   always_comb begin
      trial   = prev.r + BIT;
      next_in = prev;
      if (prev.n >= trial) begin
         next_in.n = prev.n - trial;
         next_in.r = (prev.r >> 1) + BIT;
      end else begin
         next_in.r = prev.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= '0;
      end else if (adv) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;

endmodule

### rtl/iva_cordic_cell.sv
// One micro-rotation cell of the CORDIC vectoring chain.
// Depends on iva_pkg.
module iva_cordic_cell import iva_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  cordic_stage_type prev,
   output cordic_stage_type next
);

   localparam logic signed [ACC_W-1:0] ANGLE_STEP = atan_entry(STEP);

   cordic_stage_type       next_ff, next_in;
   logic signed [XY_W-1:0] dx, dy;

   always_comb begin
      dx      = prev.y >>> STEP;
      dy      = prev.x >>> STEP;
      next_in = prev;
      if (!prev.y[XY_W-1]) begin
         next_in.x   = prev.x + dx;
         next_in.y   = prev.y - dy;
         next_in.acc = prev.acc + ANGLE_STEP;
      end else begin
         next_in.x   = prev.x - dx;
         next_in.y   = prev.y + dy;
         next_in.acc = prev.acc - ANGLE_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= '0;
      end else if (adv) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;

endmodule

### rtl/integer_vector_angle.sv
// Top level of the integer vector angle block.
// Uses iva_pkg, iva_front, iva_sqrt_cell and iva_cordic_cell.
//
// Usage:
//   Requests enter on req_* (valid/stall), results leave on rsp_* in order.
//   A request holds two vectors; csr_wr_en/csr_wr_data set the dimension
//   (2 to 4, values below 2 act as 2, above the maximum as the maximum).
//   Write the dimension only while no request is in flight.
//   Result: angle in radians scaled by 2^ANGLE_FRAC_BITS, and zero_length
//   when either vector is all zero in the components in use (angle then 0).
//   The pipeline holds 6 front stages (masking, products, sums, norm product,
//   normalization), 32 square root cells, one quadrant stage, 32 CORDIC
//   cells and the output register. Unless stalled, one request per cycle
//   is accepted. When rsp_stall holds a waiting result, the whole chain
//   freezes and req_stall rises in the same cycle; nothing is dropped.
//   Reset clears all valid bits and sets the dimension to 3.
module integer_vector_angle import iva_pkg::*; #(
   parameter int COMPONENT_BITS  = COMPONENT_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int MAX_DIMENSION   = MAX_DIMENSION_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [DIM_W-1:0]                 csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [COMPONENT_BITS-1:0] req_a_x,
   input  logic signed [COMPONENT_BITS-1:0] req_a_y,
   input  logic signed [COMPONENT_BITS-1:0] req_a_z,
   input  logic signed [COMPONENT_BITS-1:0] req_a_w,
   input  logic signed [COMPONENT_BITS-1:0] req_b_x,
   input  logic signed [COMPONENT_BITS-1:0] req_b_y,
   input  logic signed [COMPONENT_BITS-1:0] req_b_z,
   input  logic signed [COMPONENT_BITS-1:0] req_b_w,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ANGLE_FRAC_BITS+1:0]       rsp_angle,
   output logic                             rsp_zero_length
);

   localparam int ANGLE_W = ANGLE_FRAC_BITS + 2;
   localparam int RND_SH  = TAB_FRAC - ANGLE_FRAC_BITS;

   logic                             adv;
   logic [DIM_W-1:0]                 dimension_ff;
   logic signed [COMPONENT_BITS-1:0] a_comp [4];
   logic signed [COMPONENT_BITS-1:0] b_comp [4];
   sqrt_stage_type                   sq_chain [SQRT_STEPS+1];
   cordic_stage_type                 co_chain [CORDIC_STEPS+1];
   cordic_stage_type                 prep_ff, prep_in;
   logic signed [ACC_W-1:0]          acc_clamp, acc_round;
   logic                             rsp_valid_ff;
   logic [ANGLE_W-1:0]               rsp_angle_ff, rsp_angle_in;
   logic                             rsp_zero_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         dimension_ff <= csr_wr_data;
      end
   end

   assign a_comp[0] = req_a_x;
   assign a_comp[1] = req_a_y;
   assign a_comp[2] = req_a_z;
   assign a_comp[3] = req_a_w;
   assign b_comp[0] = req_b_x;
   assign b_comp[1] = req_b_y;
   assign b_comp[2] = req_b_z;
   assign b_comp[3] = req_b_w;

   iva_front #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .MAX_DIMENSION  (MAX_DIMENSION)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .accept    (req_valid && adv),
      .dimension (dimension_ff),
      .a_comp    (a_comp),
      .b_comp    (b_comp),
      .head      (sq_chain[0])
   );

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      iva_sqrt_cell #(.STEP(g)) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .prev  (sq_chain[g]),
         .next  (sq_chain[g+1])
      );
   end

   // fold the left half plane into the right one
   always_comb begin
      prep_in.valid = sq_chain[SQRT_STEPS].valid;
      prep_in.zero  = sq_chain[SQRT_STEPS].zero;
      if (sq_chain[SQRT_STEPS].x[XY_W-1]) begin
         prep_in.x   = XY_W'(sq_chain[SQRT_STEPS].r);
         prep_in.y   = -sq_chain[SQRT_STEPS].x;
         prep_in.acc = HALF_PI;
      end else begin
         prep_in.x   = sq_chain[SQRT_STEPS].x;
         prep_in.y   = XY_W'(sq_chain[SQRT_STEPS].r);
         prep_in.acc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= '0;
      end else if (adv) begin
         prep_ff <= prep_in;
      end
   end

   assign co_chain[0] = prep_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      iva_cordic_cell #(.STEP(g)) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .prev  (co_chain[g]),
         .next  (co_chain[g+1])
      );
   end

   always_comb begin
      acc_clamp = co_chain[CORDIC_STEPS].acc[ACC_W-1] ? '0 : co_chain[CORDIC_STEPS].acc;
      acc_round = acc_clamp + (ACC_W'(1) << (RND_SH - 1));
      rsp_angle_in = co_chain[CORDIC_STEPS].zero ? '0 : acc_round[RND_SH +: ANGLE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= co_chain[CORDIC_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_angle_ff <= rsp_angle_in;
         rsp_zero_ff  <= co_chain[CORDIC_STEPS].zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle       = rsp_angle_ff;
   assign rsp_zero_length = rsp_zero_ff;

endmodule

### sim/integer_vector_angle_tb.sv
// Self-checking testbench for integer_vector_angle: directed table, then random
// vector pairs over several dimension settings, with random idling on both sides.
// Depends on iva_pkg and the integer_vector_angle RTL.
`timescale 1ns / 1ps

module integer_vector_angle_tb;
   import iva_pkg::*;

   localparam int CB = COMPONENT_BITS_DEF;
   localparam int AW = ANGLE_FRAC_BITS_DEF + 2;
   localparam logic signed [CB-1:0] CMAX = 16383;
   localparam logic signed [CB-1:0] CMIN = -16384;
   localparam int LIMIT = 2000000;
   localparam int LATENCY = 72;

   typedef struct {
      logic signed [CB-1:0] c [8];
      bit                   typed;
      int                   angle;
      bit                   zl;
   } pair_row_type;

   typedef struct {
      int angle;
      bit zl;
   } angle_exp_type;

   logic clock = 0;
   logic reset;
   logic csr_wr_en;
   logic [DIM_W-1:0] csr_wr_data;
   logic req_valid, req_stall;
   logic signed [CB-1:0] req_a_x, req_a_y, req_a_z, req_a_w;
   logic signed [CB-1:0] req_b_x, req_b_y, req_b_z, req_b_w;
   logic rsp_valid, rsp_stall;
   logic [AW-1:0] rsp_angle;
   logic rsp_zero_length;

   integer_vector_angle dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   angle_exp_type angle_q[$];
   int unsigned cur_dim = 3;
   int errors = 0, accepted = 0, checked = 0, zero_seen = 0, cycles = 0;
   bit pending_typed;
   angle_exp_type pending_exp;
   int unsigned dims [8] = '{2, 4, 0, 7, 1, 5, 6, 3};

   function automatic angle_exp_type angle_of(input logic signed [CB-1:0] c [8],
                                              input int unsigned dsel);
      angle_exp_type r;
      longint na, nb, dp, s;
      int unsigned d;
      real ang;
      d = (dsel < 2) ? 2 : (dsel > 4) ? 4 : dsel;
      na = 0; nb = 0; dp = 0;
      for (int i = 0; i < d; i++) begin
         na += longint'(c[i]) * c[i];
         nb += longint'(c[4+i]) * c[4+i];
         dp += longint'(c[i]) * c[4+i];
      end
      if (na == 0 || nb == 0) begin
         r.angle = 0;
         r.zl = 1;
      end else begin
         s = na * nb - dp * dp;
         ang = $atan2($sqrt(real'(s)), real'(dp)) * 8192.0;
         r.angle = $rtoi(ang + 0.5);
         r.zl = 0;
      end
      return r;
   endfunction

   // request acceptance
   always @(posedge clock) begin
      logic signed [CB-1:0] c [8];
      angle_exp_type e;
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall) begin
         c = '{req_a_x, req_a_y, req_a_z, req_a_w, req_b_x, req_b_y, req_b_z, req_b_w};
         e = angle_of(c, cur_dim);
         if (pending_typed) e = pending_exp;
         angle_q.push_back(e);
         accepted++;
      end
   end

   // result checking
   always @(posedge clock) begin
      angle_exp_type e;
      int diff;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angle_q.size() == 0) begin
            $error("unexpected result angle=%0d zero_length=%0b", rsp_angle, rsp_zero_length);
            errors++;
         end else begin
            e = angle_q.pop_front();
            checked++;
            if (e.zl) zero_seen++;
            diff = int'(rsp_angle) - e.angle;
            if (e.zl != rsp_zero_length) begin
               $error("zero_length: expected %0b, actual %0b", e.zl, rsp_zero_length);
               errors++;
            end
            if (diff > 1 || diff < -1 || (e.zl && rsp_angle != 0)) begin
               $error("angle: expected %0d, actual %0d", e.angle, rsp_angle);
               errors++;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   initial begin
      bit pressed;
      bit hold;
      int n;
      pressed = 0;
      rsp_stall <= 0;
      @(posedge clock);
      forever begin
         if (!pressed && accepted >= 30) begin
            pressed = 1;
            rsp_stall <= 1;
            repeat (600) @(posedge clock);
         end
         n = $urandom_range(0, 9);
         hold = (n < 3);
         n = (n == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
         if ($urandom_range(0, 7) == 0) begin
            hold = 0;
            n = $urandom_range(20, 60);
         end
         rsp_stall <= hold;
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("integer_vector_angle_tb failed");
         $finish;
      end
   end

   task automatic send_pair(input logic signed [CB-1:0] c [8], input bit typed,
                            input angle_exp_type te);
      int g;
      bit stalled;
      req_valid <= 1;
      {req_a_x, req_a_y, req_a_z, req_a_w} <= {c[0], c[1], c[2], c[3]};
      {req_b_x, req_b_y, req_b_z, req_b_w} <= {c[4], c[5], c[6], c[7]};
      pending_typed <= typed;
      pending_exp <= te;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      g = $urandom_range(0, 9);
      if (g < 3) begin
         req_valid <= 0;
         g = (g == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic set_dim(input int unsigned d);
      @(posedge clock);
      while (angle_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= DIM_W'(d);
      @(posedge clock);
      csr_wr_en <= 0;
      cur_dim = d;
   endtask

   function automatic logic signed [CB-1:0] rnd_comp(input int span);
      return CB'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic random_pairs(input int count);
      logic signed [CB-1:0] c [8];
      angle_exp_type none;
      int kind, f;
      none = '{0, 0};
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         for (int i = 0; i < 8; i++)
            c[i] = (kind < 5) ? CB'($urandom) : rnd_comp(kind == 5 ? 3 : 2000);
         if (kind == 7) begin
            f = $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
            for (int i = 0; i < 4; i++) c[4+i] = CB'(c[i] * f);
         end else if (kind == 8) begin
            f = $urandom_range(0, 1) * 4;
            for (int i = 0; i < 4; i++)
               if ($urandom_range(0, 3) != 0 || i < 2) c[f+i] = 0;
         end else if (kind == 9) begin
            c[4] = -c[1]; c[5] = c[0]; c[6] = 0; c[7] = 0;
            c[2] = 0; c[3] = 0;
         end
         send_pair(c, 0, none);
      end
   endtask

   pair_row_type rows [12];

   initial begin
      angle_exp_type te;
      reset <= 1;
      csr_wr_en <= 0;
      csr_wr_data <= '0;
      req_valid <= 0;
      pending_typed <= 0;
      pending_exp <= '{0, 0};
      {req_a_x, req_a_y, req_a_z, req_a_w} <= '0;
      {req_b_x, req_b_y, req_b_z, req_b_w} <= '0;
      rows[0]  = '{'{0, 0, 0, 5, 1, 2, 3, 0}, 1, 0, 1};
      rows[1]  = '{'{1, 2, 3, 0, 0, 0, 0, 9}, 1, 0, 1};
      rows[2]  = '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 1};
      rows[3]  = '{'{CMAX, CMAX, CMAX, 0, CMAX, CMAX, CMAX, 0}, 1, 0, 0};
      rows[4]  = '{'{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN}, 1, 0, 0};
      rows[5]  = '{'{1, 2, 3, 0, -1, -2, -3, 0}, 1, 25736, 0};
      rows[6]  = '{'{CMAX, 0, 0, 0, 0, CMIN, 0, 0}, 1, 12868, 0};
      rows[7]  = '{'{CMIN, 0, 0, 0, CMAX, 0, 0, 0}, 1, 25736, 0};
      rows[8]  = '{'{0, 0, 0, CMIN, 4, 4, 4, 4}, 1, 0, 1};
      rows[9]  = '{'{CMIN, CMAX, CMIN, 0, CMAX, CMIN, CMAX, 0}, 0, 0, 0};
      rows[10] = '{'{1, 0, 0, 0, CMAX, 1, 0, 0}, 0, 0, 0};
      rows[11] = '{'{-1, -1, 1, CMAX, CMAX, CMIN, -1, 0}, 0, 0, 0};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         te = '{rows[i].angle, rows[i].zl};
         send_pair(rows[i].c, rows[i].typed, te);
      end
      random_pairs(100);
      foreach (dims[d]) begin
         req_valid <= 0;
         pending_typed <= 0;
         set_dim(dims[d]);
         random_pairs(75);
      end
      req_valid <= 0;
      pending_typed <= 0;
      @(posedge clock);
      while (angle_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d requests accepted, %0d results checked (%0d zero length)",
               accepted, checked, zero_seen);
      $display("dimension settings 0 to 7 covered, with long and short stalls on both sides");
      if (errors == 0 && angle_q.size() == 0)
         $display("integer_vector_angle_tb passed");
      else
         $display("integer_vector_angle_tb failed");
      $finish;
   end

endmodule
